FILE: rtl/ppdr_pkg.sv
// shared types, constants and the arctangent table for planar pose dead reckoning
package ppdr_pkg;

  typedef struct packed {
    logic        [31:0] time_stamp;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [19:0] yaw_rate;
  } ppdr_in_t;

  typedef struct packed {
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic        [31:0] yaw_angle;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } ppdr_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORD,
    S_MUL,
    S_CORD2,
    S_DONE
  } ppdr_state_e;

  localparam int unsigned AtanEntries = 24;
  localparam logic [31:0] DtMax       = 32'h0010_0000;
  localparam logic signed [33:0] CordicGain = 34'sh0_26DD_3B6A;

  localparam logic [31:0] ATAN_TBL [AtanEntries] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

FILE: rtl/planar_pose_dead_reckoning.sv
// top level: planar pose dead reckoning with a shared cordic stage and one multiplier
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  in      | input     | in_valid_i/in_stall_o   | in_data_i  (ppdr_in_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (ppdr_out_t)
//
// one transaction runs two passes of the single cordic micro-rotation stage,
// one step a cycle, eight steps through the one shared 36x22 multiplier,
// the final state and the idle state; in_stall_o is high from the accepting
// edge until idle
// reset clears pose, previous time stamp and the sequencer
// a result waits in the output register; a stalled output holds the sequencer in
// its final state until the register frees
module planar_pose_dead_reckoning
  import ppdr_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ppdr_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ppdr_out_t out_data_o
);

  localparam logic [4:0] LastIter = 5'(CORDIC_STEPS - 1);

  // sequencer
  ppdr_state_e state_q, state_d;
  logic [4:0]  iter_q, iter_d;
  logic [2:0]  mstep_q, mstep_d;

  // pose state
  logic        [31:0] prev_q, prev_d;
  logic signed [63:0] xacc_q, xacc_d;
  logic signed [63:0] yacc_q, yacc_d;
  logic        [31:0] yaw_q, yaw_d;

  // captured transaction
  logic        [20:0] dt_q, dt_d;
  logic signed [15:0] vx_q, vx_d;
  logic signed [15:0] vy_q, vy_d;
  logic signed [19:0] wr_q, wr_d;

  // cordic registers (Q2.30 vector, binary-angle residue)
  logic signed [33:0] cx_q, cx_d;
  logic signed [33:0] cy_q, cy_d;
  logic signed [33:0] cz_q, cz_d;
  logic               flip_q, flip_d;

  // multiplier and partial results
  logic signed [57:0] prod_q, prod_d;
  logic signed [57:0] acc_q, acc_d;
  logic signed [35:0] rx_q, rx_d;
  logic signed [35:0] ry_q, ry_d;

  logic      out_valid_q, out_valid_d;
  ppdr_out_t out_q, out_d;

  logic in_fire;
  assign in_fire = in_valid_i && !in_stall_o;

  // elapsed time, wrapped then capped at one second
  logic [31:0] dt_raw;
  assign dt_raw = in_data_i.time_stamp - prev_q;

  // cordic micro-rotation, shared by both passes
  logic signed [33:0] xs, ys, atan_s, xn, yn, zn;
  always_comb begin
    xs     = cx_q >>> iter_q;
    ys     = cy_q >>> iter_q;
    atan_s = $signed({2'b00, ATAN_TBL[iter_q]});
    if (!cz_q[33]) begin
      xn = cx_q - ys;
      yn = cy_q + xs;
      zn = cz_q - atan_s;
    end else begin
      xn = cx_q + ys;
      yn = cy_q - xs;
      zn = cz_q + atan_s;
    end
  end

  // shared multiplier operand select
  logic signed [35:0] mul_a;
  logic signed [21:0] mul_b;
  always_comb begin
    case (mstep_q)
      3'd0:    begin mul_a = 36'(cx_q); mul_b = 22'(vx_q); end
      3'd1:    begin mul_a = 36'(cy_q); mul_b = 22'(vy_q); end
      3'd2:    begin mul_a = 36'(cy_q); mul_b = 22'(vx_q); end
      3'd3:    begin mul_a = 36'(cx_q); mul_b = 22'(vy_q); end
      3'd4:    begin mul_a = rx_q;      mul_b = $signed({1'b0, dt_q}); end
      3'd5:    begin mul_a = ry_q;      mul_b = $signed({1'b0, dt_q}); end
      default: begin mul_a = 36'(wr_q); mul_b = $signed({1'b0, dt_q}); end
    endcase
  end

  logic signed [57:0] diff_s, sum_s, pshift16;
  logic        [31:0] yaw_new;
  assign diff_s   = acc_q - prod_q;
  assign sum_s    = acc_q + prod_q;
  assign pshift16 = prod_q >>> 16;
  assign yaw_new  = yaw_q + prod_q[35:4];

  // fold an angle into [-1/4, 1/4) turn, flagging a half-turn flip
  // first pass takes the heading as it stands, second pass half the new heading
  logic [31:0] fold_in, fold_ang;
  logic        fold_flip;
  assign fold_in = (state_q == S_MUL) ? {yaw_new[31], yaw_new[31:1]} : yaw_q;
  always_comb begin
    fold_flip = (fold_in[31:30] == 2'b01) || (fold_in[31:30] == 2'b10);
    fold_ang  = fold_flip ? {~fold_in[31], fold_in[30:0]} : fold_in;
  end

  // rounding of cordic results to Q1.15 with saturation
  function automatic logic signed [15:0] to_q15(logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [19:0] r;
    t = 35'(v) + 35'sd16384;
    r = 20'(t >>> 15);
    if (r > 20'sd32767)       to_q15 = 16'sh7FFF;
    else if (r < -20'sd32768) to_q15 = 16'sh8000;
    else                      to_q15 = r[15:0];
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_CORD;
      S_CORD:  if (iter_q == LastIter) state_d = S_MUL;
      S_MUL:   if (mstep_q == 3'd7) state_d = S_CORD2;
      S_CORD2: if (iter_q == LastIter) state_d = S_DONE;
      S_DONE:  if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    iter_d      = iter_q;
    mstep_d     = mstep_q;
    prev_d      = prev_q;
    xacc_d      = xacc_q;
    yacc_d      = yacc_q;
    yaw_d       = yaw_q;
    dt_d        = dt_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    wr_d        = wr_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    flip_d      = flip_q;
    prod_d      = mul_a * mul_b;
    acc_d       = acc_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          prev_d = in_data_i.time_stamp;
          dt_d   = (dt_raw > DtMax) ? 21'(DtMax) : dt_raw[20:0];
          vx_d   = in_data_i.vel_x;
          vy_d   = in_data_i.vel_y;
          wr_d   = in_data_i.yaw_rate;
          // first pass rotates by the heading from before this tick
          cx_d   = CordicGain;
          cy_d   = '0;
          cz_d   = 34'($signed(fold_ang));
          flip_d = fold_flip;
          iter_d = '0;
        end
      end
      S_CORD, S_CORD2: begin
        iter_d = iter_q + 5'd1;
        cx_d   = xn;
        cy_d   = yn;
        cz_d   = zn;
        if (iter_q == LastIter) begin
          iter_d  = '0;
          mstep_d = '0;
          if (flip_q) begin
            cx_d = -xn;
            cy_d = -yn;
          end
        end
      end
      S_MUL: begin
        mstep_d = mstep_q + 3'd1;
        case (mstep_q)
          3'd1:    acc_d = prod_q;
          3'd2:    rx_d  = 36'(diff_s >>> 14);
          3'd3:    acc_d = prod_q;
          3'd4:    ry_d  = 36'(sum_s >>> 14);
          3'd5:    xacc_d = xacc_q + 64'(pshift16);
          3'd6:    yacc_d = yacc_q + 64'(pshift16);
          3'd7: begin
            yaw_d   = yaw_new;
            // second pass: half of the new heading read as signed
            cx_d    = CordicGain;
            cy_d    = '0;
            cz_d    = 34'($signed(fold_ang));
            flip_d  = fold_flip;
            iter_d  = '0;
          end
          default: ;
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d.pos_x     = xacc_q;
          out_d.pos_y     = yacc_q;
          out_d.yaw_angle = yaw_q;
          out_d.quat_z    = to_q15(cy_q);
          out_d.quat_w    = to_q15(cx_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      mstep_q     <= '0;
      prev_q      <= '0;
      xacc_q      <= '0;
      yacc_q      <= '0;
      yaw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      mstep_q     <= mstep_d;
      prev_q      <= prev_d;
      xacc_q      <= xacc_d;
      yacc_q      <= yacc_d;
      yaw_q       <= yaw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q   <= dt_d;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    wr_q   <= wr_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    cz_q   <= cz_d;
    flip_q <= flip_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an accepted transaction keeps the input side busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> in_stall_o)
    else $error("input not held off after a transaction");

  // cordic iteration count stays inside the configured run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORD || state_q == S_CORD2) |-> (iter_q <= LastIter))
    else $error("cordic iteration count out of range");

  // a stalled result stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output transaction changed");

endmodule

FILE: tb/testbench.sv
// self-checking testbench for planar pose dead reckoning
module testbench
  import ppdr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Steps = 16;
  localparam int unsigned NumRandom = 730;

  // reduced arctangent table in 2^-32 turn, used by the predictor's own cordic
  localparam longint AngStep [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  ppdr_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  ppdr_out_t out_data_o;

  planar_pose_dead_reckoning #(.CORDIC_STEPS(Steps)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // predictor state, mirrors the pose kept by the block
  logic [31:0] last_stamp = '0;
  logic [63:0] pose_x = '0;
  logic [63:0] pose_y = '0;
  logic [31:0] heading = '0;

  ppdr_in_t  tick_queue[$];
  ppdr_out_t pose_queue[$];
  int unsigned errors = 0;
  int unsigned poses_seen = 0;
  int unsigned max_dt_ticks = 0;
  bit          in_taken = 1'b0; // input transaction accepted at the last rising edge
  bit          quiet = 1'b0;     // no random idling on either side
  bit          hold_off = 1'b0;  // receiver holds off for a long stretch
  int unsigned hold_count = 0;

  // cos and sin in Q2.30 of a binary angle; >>> on signed longint is floor
  task automatic rotate_unit(input logic [31:0] ang, output longint c, output longint s);
    longint xv, yv, zv, xs, ys;
    bit     flip;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang - 32'h8000_0000;
    xv = 64'sh26DD3B6A;
    yv = 0;
    zv = longint'(signed'(ang));
    for (int i = 0; i < Steps && i < 24; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (zv >= 0) begin
        xv -= ys; yv += xs; zv -= AngStep[i];
      end else begin
        xv += ys; yv -= xs; zv += AngStep[i];
      end
    end
    if (flip) begin
      xv = -xv; yv = -yv;
    end
    c = xv;
    s = yv;
  endtask

  function automatic logic [15:0] round_q15(input longint v);
    longint r;
    r = (v + 64'sh4000) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // advance the pose by one tick and return the expected output transaction
  task automatic advance_pose(input ppdr_in_t t, output ppdr_out_t p);
    logic [31:0] dt;
    longint c, s, vx, vy, wr, rx, ry, half;
    dt = t.time_stamp - last_stamp;
    last_stamp = t.time_stamp;
    if (dt > 32'h0010_0000) dt = 32'h0010_0000;
    if (dt == 32'h0010_0000) max_dt_ticks++;
    vx = longint'(t.vel_x);
    vy = longint'(t.vel_y);
    wr = longint'(t.yaw_rate);
    rotate_unit(heading, c, s);
    rx = (vx * c - vy * s) >>> 14;
    ry = (vx * s + vy * c) >>> 14;
    pose_x += 64'((rx * longint'(dt)) >>> 16);
    pose_y += 64'((ry * longint'(dt)) >>> 16);
    heading += 32'((wr * longint'(dt)) >>> 4);
    half = longint'(signed'(heading)) >>> 1;
    rotate_unit(half[31:0], c, s);
    p.pos_x = pose_x;
    p.pos_y = pose_y;
    p.yaw_angle = heading;
    p.quat_z = round_q15(s);
    p.quat_w = round_q15(c);
  endtask

  // driver: presents pending ticks, changes inputs at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        // the previous transaction (if any) was taken at the last rising edge
        if (tick_queue.size() != 0 && (quiet || $urandom_range(99) >= 15)) begin
          in_data_i  <= tick_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, or a long counted hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        hold_count++;
        if (hold_count >= 400) hold_off = 1'b0;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 15);
      end
    end
  end

  // prediction at acceptance, keeps order with the sampled input
  always @(posedge clk_i) begin
    ppdr_out_t p;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      advance_pose(in_data_i, p);
      pose_queue.push_back(p);
    end
  end

  // monitor: compares every output transaction with the oldest prediction
  always @(posedge clk_i) begin
    ppdr_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      poses_seen++;
      if (pose_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction %h", $realtime, out_data_o);
      end else begin
        e = pose_queue.pop_front();
        if (out_data_o.pos_x !== e.pos_x) begin
          errors++;
          $display("%0t: pos_x expected %h actual %h", $realtime, e.pos_x, out_data_o.pos_x);
        end
        if (out_data_o.pos_y !== e.pos_y) begin
          errors++;
          $display("%0t: pos_y expected %h actual %h", $realtime, e.pos_y, out_data_o.pos_y);
        end
        if (out_data_o.yaw_angle !== e.yaw_angle) begin
          errors++;
          $display("%0t: yaw_angle expected %h actual %h", $realtime, e.yaw_angle,
                   out_data_o.yaw_angle);
        end
        if (out_data_o.quat_z !== e.quat_z) begin
          errors++;
          $display("%0t: quat_z expected %h actual %h", $realtime, e.quat_z, out_data_o.quat_z);
        end
        if (out_data_o.quat_w !== e.quat_w) begin
          errors++;
          $display("%0t: quat_w expected %h actual %h", $realtime, e.quat_w, out_data_o.quat_w);
        end
      end
    end
  end

  function automatic ppdr_in_t make_tick(logic [31:0] ts, logic [15:0] vx, logic [15:0] vy,
                                         logic [19:0] wr);
    ppdr_in_t t;
    t.time_stamp = ts;
    t.vel_x = vx;
    t.vel_y = vy;
    t.yaw_rate = wr;
    return t;
  endfunction

  // stimulus and end of run
  initial begin
    logic [31:0] clock_now;
    ppdr_in_t    t;
    int unsigned waited;
    // directed: a capped gap, extremes, backwards time, zero gap
    tick_queue.push_back(make_tick(32'h0000_4000, 16'h7FFF, 16'h0000, 20'h00000));
    tick_queue.push_back(make_tick(32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 20'h7FFFF));
    tick_queue.push_back(make_tick(32'h0000_0100, 16'h7FFF, 16'h8000, 20'h80000));
    tick_queue.push_back(make_tick(32'h0000_0100, 16'h1234, 16'hFEDC, 20'h7FFFF));
    tick_queue.push_back(make_tick(32'h0000_0000, 16'hFFFF, 16'hFFFF, 20'hFFFFF));
    tick_queue.push_back(make_tick(32'h0010_0000, 16'h8000, 16'h8000, 20'h40000));
    tick_queue.push_back(make_tick(32'h0020_0001, 16'h7FFF, 16'h7FFF, 20'h7FFFF));
    tick_queue.push_back(make_tick(32'h8000_0000, 16'h0001, 16'h0001, 20'h00001));
    // steady ticks at full yaw rate with a gap below the cap
    clock_now = 32'h8000_0000;
    for (int i = 0; i < 10; i++) begin
      clock_now += 32'h000C_0000;
      tick_queue.push_back(make_tick(clock_now, 16'h7FFF, 16'h8000, 20'h7FFFF));
    end
    // long forward jump in time with the body at rest
    tick_queue.push_back(make_tick(clock_now + 32'h4000_0000, 16'h0000, 16'h0000, 20'h00000));
    clock_now += 32'h4000_0000;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // random: mostly steady ticks, sometimes big jumps or time going back
    for (int i = 0; i < NumRandom; i++) begin
      case ($urandom_range(9))
        0: clock_now = $urandom;
        1: clock_now += $urandom_range(32'h0030_0000, 32'h0010_0000);
        default: clock_now += $urandom_range(32'h0002_0000);
      endcase
      t.time_stamp = clock_now;
      t.vel_x = 16'($urandom);
      t.vel_y = 16'($urandom);
      t.yaw_rate = 20'($urandom);
      tick_queue.push_back(t);
      if (i == 150) begin
        // long receiver hold-off while the sender keeps offering
        hold_count = 0;
        hold_off = 1'b1;
      end
      if (i == 400) quiet = 1'b1;
      if (i == 500) quiet = 1'b0;
      while (tick_queue.size() > 4) @(posedge clk_i);
    end

    while (tick_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    waited = 0;
    while (pose_queue.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (60) @(posedge clk_i);
    $display("ran %0d ticks, checked %0d poses, %0d with a capped one-second gap",
             NumRandom + 19, poses_seen, max_dt_ticks);
    if (errors == 0 && pose_queue.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12ns * 400000);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
